[design/udp_message_frame_checker_unit_defines.svh]
// Assertion macros used by the frame checker top-level design file.
`ifndef UDP_MESSAGE_FRAME_CHECKER_UNIT_DEFINES_SVH
`define UDP_MESSAGE_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UMFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UMFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/umfc_pkg.sv]
// Types and constants shared by the message frame checker modules.
package umfc_pkg;

   localparam int HEADER_BYTES = 14;
   localparam int POS_WIDTH = 16;
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
   localparam logic [POS_WIDTH-1:0] MIN_FRAME_BYTES = POS_WIDTH'(HEADER_BYTES + 1);
   localparam logic [31:0] ID_INVALID = '1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_SHORT         = 3'd1,
      STATUS_BAD_ID        = 3'd2,
      STATUS_SIZE_MISMATCH = 3'd3,
      STATUS_BAD_END       = 3'd4,
      STATUS_ZERO_ADDRESS  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_payload_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         payload_byte;
      logic signed [31:0] message_id;
      logic [15:0]        size_field;
      logic [31:0]        ip_address;
      logic signed [31:0] port_number;
      logic [2:0]         status;
   } rsp_payload_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] position;
      logic [31:0]          message_id;
      logic [15:0]          size_field;
      logic [31:0]          ip_address;
      logic [31:0]          port_number;
   } frame_state_type;

endpackage

[design/udp_message_frame_checker_unit.sv]
// Top level of the message frame checker: input register, result register, control register.
//
// Usage: raw frame bytes enter on the req_ channel, one transaction per byte,
// with frame_end set on the last byte of each frame. The first fourteen bytes
// of a frame are header and give no result unless one is the last. Every later
// byte that is not the last is returned on the rsp_ channel as a payload
// transaction; the last byte returns one verdict transaction with the header
// fields and status. The user writes the expected end marker through
// csr_write_enable/csr_write_data while no frame byte is in flight; the block
// itself does not enforce this. An accepted byte passes the input register,
// then the result register. While req_stall is low a byte is taken every cycle;
// the rate is set by the single pass from the input register through the
// position counter and verdict logic into the result register. Reset clears the
// position counter, captured header fields, end marker and both valid flags.
// Under rsp_stall with rsp_valid set the result register holds; a byte with a
// result waits in the input register, raising req_stall; header bytes drain.
`include "udp_message_frame_checker_unit_defines.svh"
module udp_message_frame_checker_unit
   import umfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [7:0]      csr_write_data
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_payload_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   logic [7:0]      end_marker_ff;
   logic [7:0]      end_marker_in;

   frame_state_type merged;
   rsp_payload_type result;
   logic            has_result;
   logic            out_free;
   logic            advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !advance;

   umfc_frame_state u_frame_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_payload_ff),
      .merged  (merged)
   );

   umfc_verdict u_verdict (
      .merged     (merged),
      .item       (in_payload_ff),
      .end_marker (end_marker_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance && has_result;
      end
      end_marker_in = csr_write_enable ? csr_write_data : end_marker_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         end_marker_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         end_marker_ff <= end_marker_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_payload_ff <= req_payload;
      end
      if (out_free && advance && has_result) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `UMFC_ASSERT_SAME(a_stall_needs_item, clock, reset, !in_valid_ff, !req_stall, "stall without a held byte")
   `UMFC_ASSERT_NEXT(a_frame_end_clears, clock, reset, advance && in_payload_ff.frame_end, merged.position == '0, "position not cleared after frame end")
   `UMFC_ASSERT_SAME(a_payload_fields_zero, clock, reset, rsp_valid_ff && (rsp_payload_ff.kind == KIND_PAYLOAD), (rsp_payload_ff.status == '0) && (rsp_payload_ff.size_field == '0), "payload result carries verdict fields")
   `UMFC_ASSERT_SAME(a_ok_frame_long_enough, clock, reset, rsp_valid_ff && (rsp_payload_ff.kind == KIND_VERDICT) && (rsp_payload_ff.status == STATUS_OK), rsp_payload_ff.size_field >= MIN_FRAME_BYTES, "accepted frame shorter than minimum")

endmodule

[design/umfc_frame_state.sv]
// Byte position counter and header capture registers for the current frame.
module umfc_frame_state
   import umfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_payload_type item,
   output frame_state_type merged
);

   frame_state_type state_ff;
   frame_state_type state_in;

   // Current state with the incoming byte already placed in its header slot.
   always_comb begin
      merged = state_ff;
      if (state_ff.position < POS_WIDTH'(HEADER_BYTES)) begin
         unique case (state_ff.position[3:0])
            4'd0:  merged.message_id[7:0]   = item.data_byte;
            4'd1:  merged.message_id[15:8]  = item.data_byte;
            4'd2:  merged.message_id[23:16] = item.data_byte;
            4'd3:  merged.message_id[31:24] = item.data_byte;
            4'd4:  merged.size_field[7:0]   = item.data_byte;
            4'd5:  merged.size_field[15:8]  = item.data_byte;
            4'd6:  merged.ip_address[31:24] = item.data_byte;
            4'd7:  merged.ip_address[23:16] = item.data_byte;
            4'd8:  merged.ip_address[15:8]  = item.data_byte;
            4'd9:  merged.ip_address[7:0]   = item.data_byte;
            4'd10: merged.port_number[7:0]   = item.data_byte;
            4'd11: merged.port_number[15:8]  = item.data_byte;
            4'd12: merged.port_number[23:16] = item.data_byte;
            4'd13: merged.port_number[31:24] = item.data_byte;
            default: merged = state_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         if (item.frame_end) begin
            state_in = '0;
         end else begin
            state_in = merged;
            if (state_ff.position != POS_MAX) begin
               state_in.position = state_ff.position + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/umfc_verdict.sv]
// Result formation: payload pass-through and the prioritised frame verdict.
module umfc_verdict
   import umfc_pkg::*;
(
   input  frame_state_type merged,
   input  req_payload_type item,
   input  logic [7:0]      end_marker,
   output logic            has_result,
   output rsp_payload_type result
);

   logic [POS_WIDTH-1:0] byte_count;
   status_type           status;

   assign byte_count = (merged.position == POS_MAX) ? POS_MAX : merged.position + 1'b1;

   always_comb begin
      priority if (byte_count < MIN_FRAME_BYTES) begin
         status = STATUS_SHORT;
      end else if (merged.message_id == ID_INVALID) begin
         status = STATUS_BAD_ID;
      end else if (merged.size_field != byte_count) begin
         status = STATUS_SIZE_MISMATCH;
      end else if (item.data_byte != end_marker) begin
         status = STATUS_BAD_END;
      end else if (merged.ip_address == '0) begin
         status = STATUS_ZERO_ADDRESS;
      end else begin
         status = STATUS_OK;
      end
   end

   assign has_result = item.frame_end || (merged.position >= POS_WIDTH'(HEADER_BYTES));

   always_comb begin
      result = '0;
      if (item.frame_end) begin
         result.kind        = KIND_VERDICT;
         result.message_id  = signed'(merged.message_id);
         result.size_field  = merged.size_field;
         result.ip_address  = merged.ip_address;
         result.port_number = signed'(merged.port_number);
         result.status      = status;
      end else begin
         result.kind         = KIND_PAYLOAD;
         result.payload_byte = item.data_byte;
      end
   end

endmodule

[verif/testbench.sv]
// Self-checking testbench for the message frame checker: frame stimulus, prediction and checking.
module testbench;
   import umfc_pkg::*;

   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int PHASE_BYTES = 250;
   localparam int SETTLE_CYCLES = 6;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [7:0]      csr_write_data = '0;

   udp_message_frame_checker_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   req_payload_type frame_bytes_pending[$];
   rsp_payload_type frame_results_due[$];
   rsp_payload_type next_due;

   logic [15:0] frame_pos = '0;
   logic [31:0] frame_id = '0;
   logic [15:0] frame_size = '0;
   logic [31:0] frame_address = '0;
   logic [31:0] frame_port = '0;
   logic [7:0]  end_marker_shadow = '0;

   bit sender_idle_on = 1'b0;
   bit receiver_idle_on = 1'b0;
   int sender_gap = 0;
   int receiver_hold = 0;
   int queued_bytes = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Tracks the frame state for each accepted byte and records the transaction it should give.
   task automatic track_frame_byte(input req_payload_type item);
      rsp_payload_type expected;
      int p;
      logic [15:0] count;
      expected = '0;
      p = frame_pos;
      if (p < 4) begin
         frame_id[8*p +: 8] = item.data_byte;
      end else if (p < 6) begin
         frame_size[8*(p-4) +: 8] = item.data_byte;
      end else if (p < 10) begin
         frame_address[8*(9-p) +: 8] = item.data_byte;
      end else if (p < HEADER_BYTES) begin
         frame_port[8*(p-10) +: 8] = item.data_byte;
      end
      if (!item.frame_end) begin
         if (frame_pos != POS_MAX) frame_pos = frame_pos + 16'd1;
         if (p >= HEADER_BYTES) begin
            expected.kind = KIND_PAYLOAD;
            expected.payload_byte = item.data_byte;
            frame_results_due = {frame_results_due, expected};
         end
      end else begin
         count = (frame_pos != POS_MAX) ? frame_pos + 16'd1 : POS_MAX;
         if (count < MIN_FRAME_BYTES) begin
            expected.status = STATUS_SHORT;
         end else if (frame_id == ID_INVALID) begin
            expected.status = STATUS_BAD_ID;
         end else if (frame_size != count) begin
            expected.status = STATUS_SIZE_MISMATCH;
         end else if (item.data_byte != end_marker_shadow) begin
            expected.status = STATUS_BAD_END;
         end else if (frame_address == '0) begin
            expected.status = STATUS_ZERO_ADDRESS;
         end else begin
            expected.status = STATUS_OK;
         end
         expected.kind = KIND_VERDICT;
         expected.message_id = frame_id;
         expected.size_field = frame_size;
         expected.ip_address = frame_address;
         expected.port_number = frame_port;
         frame_results_due = {frame_results_due, expected};
         frame_pos = '0;
         frame_id = '0;
         frame_size = '0;
         frame_address = '0;
         frame_port = '0;
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] seen,
                                input logic [31:0] want);
      if (seen !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected %h, got %h", field, want, seen);
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] value, input logic is_last);
      req_payload_type item;
      item.data_byte = value;
      item.frame_end = is_last;
      frame_bytes_pending = {frame_bytes_pending, item};
      queued_bytes++;
   endtask

   task automatic queue_frame(input logic [31:0] id, input logic [15:0] size,
                              input logic [31:0] address, input logic [31:0] port,
                              input int payload_len, input logic [7:0] closing);
      for (int i = 0; i < 4; i++) push_byte(id[8*i +: 8], 1'b0);
      for (int i = 0; i < 2; i++) push_byte(size[8*i +: 8], 1'b0);
      for (int i = 3; i >= 0; i--) push_byte(address[8*i +: 8], 1'b0);
      for (int i = 0; i < 4; i++) push_byte(port[8*i +: 8], 1'b0);
      for (int i = 0; i < payload_len; i++) push_byte(8'($urandom), 1'b0);
      push_byte(closing, 1'b1);
   endtask

   task automatic queue_short_frame(input int len);
      for (int i = 1; i < len; i++) push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b1);
   endtask

   task automatic queue_random_frame();
      int choice;
      int payload_len;
      logic [31:0] id;
      logic [31:0] address;
      logic [15:0] size;
      logic [7:0]  closing;
      choice = $urandom_range(0, 19);
      if (choice == 0) begin
         queue_short_frame($urandom_range(1, 14));
      end else if (choice == 1) begin
         payload_len = $urandom_range(1, 30);
         for (int i = 0; i < payload_len; i++) begin
            push_byte(8'($urandom), $urandom_range(0, 9) == 0);
         end
         push_byte(8'($urandom), 1'b1);
      end else begin
         payload_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         id = $urandom;
         if ($urandom_range(0, 11) == 0) id = ID_INVALID;
         address = $urandom;
         if ($urandom_range(0, 11) == 0) address = '0;
         size = 16'(HEADER_BYTES + 1 + payload_len);
         if ($urandom_range(0, 9) == 0) size = 16'($urandom);
         else if ($urandom_range(0, 9) == 0) size = size + 16'd1;
         closing = end_marker_shadow;
         if ($urandom_range(0, 9) == 0) closing = 8'($urandom);
         queue_frame(id, size, address, $urandom, payload_len, closing);
      end
   endtask

   task automatic write_end_marker(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      end_marker_shadow = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle();
      while (frame_bytes_pending.size() != 0 || req_valid || frame_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_valid && !req_stall) track_frame_byte(req_payload);
         if (!req_valid || !req_stall) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_valid <= 1'b0;
            end else if (frame_bytes_pending.size() != 0) begin
               req_payload <= frame_bytes_pending.pop_front();
               req_valid <= 1'b1;
               if (sender_idle_on && $urandom_range(0, 5) == 0) begin
                  sender_gap = $urandom_range(1, 16);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         receiver_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected transaction: %p", rsp_payload);
               end
            end else begin
               next_due = frame_results_due.pop_front();
               compare_field("kind", rsp_payload.kind, next_due.kind);
               compare_field("payload_byte", rsp_payload.payload_byte, next_due.payload_byte);
               compare_field("message_id", rsp_payload.message_id, next_due.message_id);
               compare_field("size_field", rsp_payload.size_field, next_due.size_field);
               compare_field("ip_address", rsp_payload.ip_address, next_due.ip_address);
               compare_field("port_number", rsp_payload.port_number, next_due.port_number);
               compare_field("status", rsp_payload.status, next_due.status);
            end
         end
         if (receiver_hold > 0) begin
            receiver_hold--;
            rsp_stall <= 1'b1;
         end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            receiver_hold = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      int phase_start;
      logic [7:0] phase_markers[4];
      phase_markers = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom)};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;

      // The end marker still holds its reset value of zero here.
      queue_short_frame(1);
      queue_short_frame(14);
      queue_frame(32'h0000_0000, 16'd15, 32'h0000_0001, 32'h0000_0000, 0, 8'h00);
      queue_frame(32'hFFFF_FFFF, 16'd99, 32'h0A00_0001, 32'h1234_5678, 2, 8'h00);
      queue_frame(32'h8000_0000, 16'd16, 32'h0A00_0001, 32'h7FFF_FFFF, 0, 8'hFF);
      queue_frame(32'h7FFF_FFFF, 16'd17, 32'h0000_0000, 32'h8000_0000, 1, 8'h3C);
      queue_frame(32'h0102_0304, 16'd15, 32'h0000_0000, 32'hFFFF_FFFF, 0, 8'h00);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      queue_frame(32'hFFFF_FFFE, 16'd18, 32'hFFFF_FFFF, 32'h0000_0001, 3, 8'h00);
      settle();

      foreach (phase_markers[i]) begin
         write_end_marker(phase_markers[i]);
         phase_start = queued_bytes;
         while (queued_bytes - phase_start < PHASE_BYTES) queue_random_frame();
         settle();
      end

      // Closing stretch without idling.
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      write_end_marker(8'($urandom));
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < 250) queue_random_frame();
      settle();

      mismatch_count += frame_results_due.size();
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

[udp_message_frame_checker_unit.f]
+incdir+design
design/umfc_pkg.sv
design/umfc_frame_state.sv
design/umfc_verdict.sv
design/udp_message_frame_checker_unit.sv
verif/testbench.sv
